// ===== src/sca_pkg.sv =====
// Shared types, codes and decode tables for the ATR parser.
package sca_pkg;

  localparam int MAX_LEVELS    = 8;
  localparam int MAX_ATR_BYTES = 64;

  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_WAIT_TS = 3'd0;
  localparam logic [PHASE_W-1:0] PH_T0      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_IFACE   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HIST    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

  localparam logic [3:0] KIND_SKIP = 4'd0;
  localparam logic [3:0] KIND_TS   = 4'd1;
  localparam logic [3:0] KIND_T0   = 4'd2;
  localparam logic [3:0] KIND_TA   = 4'd3;
  localparam logic [3:0] KIND_TB   = 4'd4;
  localparam logic [3:0] KIND_TC   = 4'd5;
  localparam logic [3:0] KIND_TD   = 4'd6;
  localparam logic [3:0] KIND_HIST = 4'd7;
  localparam logic [3:0] KIND_END  = 4'd8;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [3:0]         pending;
    logic [3:0]         level;
    logic [3:0]         hist_left;
    logic [3:0]         hist_total;
    logic [6:0]         byte_count;
    logic [3:0]         fi;
    logic [3:0]         di;
    logic [7:0]         guard;
    logic [3:0]         protocol;
    logic               conv;
    logic               ovf;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_WAIT_TS,
    pending:    4'd0,
    level:      4'd0,
    hist_left:  4'd0,
    hist_total: 4'd0,
    byte_count: 7'd0,
    fi:         4'd1,
    di:         4'd1,
    guard:      8'd0,
    protocol:   4'd0,
    conv:       1'b1,
    ovf:        1'b0
  };

  // Clock rate conversion factor F, zero for all other codes.
  function automatic logic [11:0] clock_factor_lut(input logic [3:0] fi);
    logic [11:0] f;
    case (fi)
      4'd1:    f = 12'd372;
      4'd2:    f = 12'd558;
      4'd3:    f = 12'd744;
      4'd4:    f = 12'd1116;
      4'd5:    f = 12'd1488;
      4'd6:    f = 12'd1860;
      4'd9:    f = 12'd512;
      4'd10:   f = 12'd768;
      4'd11:   f = 12'd1024;
      4'd12:   f = 12'd1536;
      4'd13:   f = 12'd2048;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

  // Baud rate adjustment factor D for codes 1 to 5, zero for all other codes.
  function automatic logic [4:0] rate_factor_lut(input logic [3:0] di);
    logic [4:0] d;
    case (di)
      4'd1:    d = 5'd1;
      4'd2:    d = 5'd2;
      4'd3:    d = 5'd4;
      4'd4:    d = 5'd8;
      4'd5:    d = 5'd16;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/sca_if.sv =====
// Valid/ready channel interfaces for ATR bytes in and parse results out.
interface sca_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] atr_byte;

  modport source (output valid, output restart, output atr_byte, input ready);
  modport sink   (input valid, input restart, input atr_byte, output ready);
endinterface

interface sca_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_kind;
  logic [3:0]  level;
  logic        direct_convention;
  logic [3:0]  fi_code;
  logic [3:0]  di_code;
  logic [11:0] clock_factor;
  logic [4:0]  rate_factor;
  logic [7:0]  extra_guard;
  logic [3:0]  first_protocol;
  logic [3:0]  history_count;
  logic        complete;
  logic        overflow;

  modport source (
    output valid, output byte_kind, output level, output direct_convention,
    output fi_code, output di_code, output clock_factor, output rate_factor,
    output extra_guard, output first_protocol, output history_count,
    output complete, output overflow, input ready
  );
  modport sink (
    input valid, input byte_kind, input level, input direct_convention,
    input fi_code, input di_code, input clock_factor, input rate_factor,
    input extra_guard, input first_protocol, input history_count,
    input complete, input overflow, output ready
  );
endinterface

// ===== src/sca_step.sv =====
// Combinational parse step: one ATR byte against the current parse state.
module sca_step (
  input  sca_pkg::parse_state_t state_i,
  input  logic                  restart_i,
  input  logic [7:0]            byte_i,
  output sca_pkg::parse_state_t state_o,
  output logic [3:0]            kind_o,
  output logic [3:0]            level_o
);
  import sca_pkg::*;

  // Where to go once the current level's interface bytes are used up.
  function automatic logic [PHASE_W-1:0] next_phase(input logic [3:0] pend,
                                                    input logic [3:0] left);
    logic [PHASE_W-1:0] p;
    if (pend != 4'd0)      p = PH_IFACE;
    else if (left != 4'd0) p = PH_HIST;
    else                   p = PH_DONE;
    return p;
  endfunction

  parse_state_t s;
  parse_state_t n;
  logic [1:0]   slot;
  logic [3:0]   left_dec;

  always_comb begin
    s = restart_i ? STATE_RESET : state_i;
    n = s;
    kind_o = KIND_SKIP;
    level_o = 4'd0;

    // Lowest pending interface byte; TD when none of TA..TC remain.
    if (s.pending[0])      slot = 2'd0;
    else if (s.pending[1]) slot = 2'd1;
    else if (s.pending[2]) slot = 2'd2;
    else                   slot = 2'd3;

    left_dec = (s.hist_left != 4'd0) ? s.hist_left - 4'd1 : s.hist_left;

    if (s.phase == PH_WAIT_TS) begin
      if (byte_i == TS_DIRECT || byte_i == TS_INVERSE) begin
        kind_o       = KIND_TS;
        n.conv       = (byte_i == TS_DIRECT);
        n.byte_count = 7'd1;
        n.phase      = PH_T0;
      end
    end else if (s.byte_count >= 7'(MAX_ATR_BYTES)) begin
      n.ovf  = 1'b1;
      kind_o = KIND_END;
    end else begin
      n.byte_count = s.byte_count + 7'd1;
      case (s.phase)
        PH_T0: begin
          kind_o       = KIND_T0;
          n.hist_total = byte_i[3:0];
          n.hist_left  = byte_i[3:0];
          n.pending    = byte_i[7:4];
          n.level      = 4'd1;
          n.phase      = next_phase(byte_i[7:4], byte_i[3:0]);
        end
        PH_IFACE: begin
          kind_o    = KIND_TA + {2'b00, slot};
          level_o   = s.level;
          n.pending = s.pending & ~(4'd1 << slot);
          case (slot)
            2'd0: begin
              if (s.level == 4'd1) begin
                n.fi = byte_i[7:4];
                n.di = byte_i[3:0];
              end
            end
            2'd2: begin
              if (s.level == 4'd1) n.guard = byte_i;
            end
            2'd3: begin
              if (s.level == 4'd1) n.protocol = byte_i[3:0];
              if (byte_i[7:4] == 4'd0) begin
                n.pending = 4'd0;
              end else if (s.level >= 4'(MAX_LEVELS)) begin
                // chain too deep: drop the announced bytes
                n.ovf     = 1'b1;
                n.pending = 4'd0;
              end else begin
                n.level   = s.level + 4'd1;
                n.pending = byte_i[7:4];
              end
            end
            default: ;
          endcase
          n.phase = next_phase(n.pending, s.hist_left);
        end
        PH_HIST: begin
          kind_o      = KIND_HIST;
          n.hist_left = left_dec;
          if (left_dec == 4'd0) n.phase = PH_DONE;
        end
        default: kind_o = KIND_END;
      endcase
    end

    state_o = n;
  end

endmodule

// ===== src/smart_card_atr_parser.sv =====
// ATR parser top level: input register, parse step, result register.
// Path: a byte accepted into the input register is stepped into the result register
//   once that register is free or draining, and is then offered as a result beat.
// Throughput: one byte per cycle while the result sink is ready; the parse state loop is a
//   single step of small combinational logic from the input register to the result register.
// Reset (rst_ni low, asynchronous): both stages empty, parse state back to
//   waiting for TS with Fi = Di = 1, direct convention, no overflow.
module smart_card_atr_parser (
  input  logic clk_i,
  input  logic rst_ni,
  sca_in_if.sink    in_i,
  sca_out_if.source out_o
);
  import sca_pkg::*;

  // Input stage
  logic       in_vld_q;
  logic       in_restart_q;
  logic [7:0] in_byte_q;

  // Parse state, updated once per stepped byte
  parse_state_t st_q;
  parse_state_t st_d;
  logic [3:0]   kind_d;
  logic [3:0]   level_d;

  // Result stage
  logic         out_vld_q;
  logic [3:0]   kind_q;
  logic [3:0]   level_q;
  parse_state_t res_q;

  logic advance;

  // Step when a byte is held and the result register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_restart_q <= in_i.restart;
      in_byte_q    <= in_i.atr_byte;
    end
  end

  sca_step u_step (
    .state_i   (st_q),
    .restart_i (in_restart_q),
    .byte_i    (in_byte_q),
    .state_o   (st_d),
    .kind_o    (kind_d),
    .level_o   (level_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= STATE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) st_q <= st_d;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result beat carries the label plus a snapshot of the state after this byte.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind_d;
      level_q <= level_d;
      res_q   <= st_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.byte_kind         = kind_q;
  assign out_o.level             = level_q;
  assign out_o.direct_convention = res_q.conv;
  assign out_o.fi_code           = res_q.fi;
  assign out_o.di_code           = res_q.di;
  assign out_o.clock_factor      = clock_factor_lut(res_q.fi);
  assign out_o.rate_factor       = rate_factor_lut(res_q.di);
  assign out_o.extra_guard       = res_q.guard;
  assign out_o.first_protocol    = res_q.protocol;
  assign out_o.history_count     = res_q.hist_total;
  assign out_o.complete          = (res_q.phase == PH_DONE);
  assign out_o.overflow          = res_q.ovf;

  // Interface phase exactly when interface bytes are still owed.
  a_iface_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_IFACE) == (st_q.pending != 4'd0))
    else $error("interface phase and pending mask disagree");

  a_byte_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.byte_count <= 7'(MAX_ATR_BYTES))
    else $error("byte count beyond limit");

  a_level_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.level <= 4'(MAX_LEVELS))
    else $error("interface level beyond limit");

  // Overflow only clears through a restart byte.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.ovf && !(advance && in_restart_q) |=> st_q.ovf)
    else $error("overflow flag dropped without restart");

  // Interface bytes always carry a nonzero level.
  a_iface_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (kind_q == KIND_TA || kind_q == KIND_TB || kind_q == KIND_TC ||
                  kind_q == KIND_TD) |-> level_q != 4'd0)
    else $error("interface byte labelled with level zero");

endmodule
